// ===== rtl/tptf_pkg.sv =====
// ----------------------------------------------------------------------------
// tptf_pkg: shared constants for the two-pole TPT audio filter
// Field widths, register indexes, mode codes and parameter defaults.
// ----------------------------------------------------------------------------
package tptf_pkg;

	// parameter defaults
	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int STATE_WIDTH_DEF    = 24;
	localparam int COEF_FRAC_BITS_DEF = 16;

	// fixed field widths
	localparam int LEVEL_WIDTH     = 24;
	localparam int COEF_WIDTH      = 16;
	localparam int RES_FRAC_BITS   = 14;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 16;

	// register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE      = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CUTOFF    = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESONANCE = 2'd2;

	// filter modes
	localparam logic MODE_LOWPASS  = 1'b0;
	localparam logic MODE_HIGHPASS = 1'b1;

endpackage

// ===== rtl/tptf_in_if.sv =====
// ----------------------------------------------------------------------------
// tptf_in_if: sample request channel
// Valid/ready channel carrying one audio sample and its clear flag.
// ----------------------------------------------------------------------------
interface tptf_in_if #(
	parameter int SAMPLE_WIDTH = tptf_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           clear_first;

	modport source (output valid, output sample, output clear_first, input ready);
	modport sink   (input valid, input sample, input clear_first, output ready);
endinterface

// ===== rtl/tptf_out_if.sv =====
// ----------------------------------------------------------------------------
// tptf_out_if: filtered result channel
// Valid/ready channel carrying one filtered level and its clamp flag.
// ----------------------------------------------------------------------------
interface tptf_out_if;
	import tptf_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [LEVEL_WIDTH-1:0] level;
	logic                          saturated;

	modport source (output valid, output level, output saturated, input ready);
	modport sink   (input valid, input level, input saturated, output ready);
endinterface

// ===== rtl/tptf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tptf_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tptf_cfg_if;
	import tptf_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CFG_INDEX_WIDTH-1:0] index;
	logic [CFG_DATA_WIDTH-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/two_pole_tpt_audio_filter_core.sv =====
// ----------------------------------------------------------------------------
// two_pole_tpt_audio_filter_core: two-pole TPT audio filter
// Resonant lowpass or cascaded highpass built from two trapezoidal
// integrators, sharing one multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel    | dir | payload                       | handshake
//  -----------+-----+-------------------------------+-------------
//  cfg        | in  | index, data                   | valid/ready
//  audio      | in  | sample, clear_first           | valid/ready
//  filtered   | out | level, saturated              | valid/ready
//
//  Lowpass steps: feedback product, input sum, then a product and an update
//  for each integrator; highpass steps: a product and an update for each one.
//  One multiplier serves every product in turn; a new sample is taken only
//  in idle. Reset clears the configuration registers, the integrator state
//  and the sequencer. A result waits in the output register while the next
//  sample is taken; the last update step holds while that register is still full.
//
module two_pole_tpt_audio_filter_core #(
	parameter int SAMPLE_WIDTH   = tptf_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_WIDTH    = tptf_pkg::STATE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = tptf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tptf_cfg_if.sink    cfg,
	tptf_in_if.sink     audio,
	tptf_out_if.source  filtered
);
	import tptf_pkg::*;

	// datapath widths
	localparam int MAXW = (SAMPLE_WIDTH > STATE_WIDTH) ? SAMPLE_WIDTH : STATE_WIDTH;
	localparam int DW   = MAXW + 2;
	localparam int BW   = COEF_WIDTH + 1;
	localparam int PW   = DW + BW;
	localparam int XW   = PW + 2;

	localparam logic signed [XW-1:0] ST_HI = (XW'(1) <<< (STATE_WIDTH - 1)) - XW'(1);
	localparam logic signed [XW-1:0] ST_LO = ~ST_HI;
	localparam logic signed [XW-1:0] LV_HI = (XW'(1) <<< (LEVEL_WIDTH - 1)) - XW'(1);
	localparam logic signed [XW-1:0] LV_LO = ~LV_HI;

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FB   = 3'd1;
	localparam logic [2:0] ST_U    = 3'd2;
	localparam logic [2:0] ST_M1   = 3'd3;
	localparam logic [2:0] ST_F1   = 3'd4;
	localparam logic [2:0] ST_M2   = 3'd5;
	localparam logic [2:0] ST_F2   = 3'd6;

	// round half up, then truncate toward zero
	function automatic logic signed [XW-1:0] rnd(input logic signed [PW-1:0] p,
			input int unsigned f);
		logic signed [XW-1:0] t;
		logic signed [XW-1:0] q;
		logic        [XW-1:0] mask;
		mask = (XW'(1) << f) - XW'(1);
		t    = XW'(p) + (XW'(1) << (f - 1));
		q    = t >>> f;
		if (t[XW-1] && ((t & mask) != '0))
			q = q + XW'(1);
		return q;
	endfunction

	// clamp to the state range: {flag, value}
	function automatic logic [STATE_WIDTH:0] sat_st(input logic signed [XW-1:0] x);
		if (x > ST_HI)
			return {1'b1, ST_HI[STATE_WIDTH-1:0]};
		else if (x < ST_LO)
			return {1'b1, ST_LO[STATE_WIDTH-1:0]};
		else
			return {1'b0, x[STATE_WIDTH-1:0]};
	endfunction

	// clamp to the level range: {flag, value}
	function automatic logic [LEVEL_WIDTH:0] sat_lv(input logic signed [XW-1:0] x);
		if (x > LV_HI)
			return {1'b1, LV_HI[LEVEL_WIDTH-1:0]};
		else if (x < LV_LO)
			return {1'b1, LV_LO[LEVEL_WIDTH-1:0]};
		else
			return {1'b0, x[LEVEL_WIDTH-1:0]};
	endfunction

	// control and state registers
	logic [2:0]                    state_q;
	logic                          out_valid_q;
	logic                          mode_q;
	logic [COEF_WIDTH-1:0]         coef_q;
	logic [COEF_WIDTH-1:0]         gain_q;
	logic signed [STATE_WIDTH-1:0] s1_q;
	logic signed [STATE_WIDTH-1:0] s2_q;
	logic signed [STATE_WIDTH-1:0] o1_q;
	logic signed [STATE_WIDTH-1:0] o2_q;

	// payload registers
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [STATE_WIDTH-1:0]  drive_q;
	logic signed [PW-1:0]           prod_q;
	logic                           sat_q;
	logic signed [LEVEL_WIDTH-1:0]  level_q;
	logic                           out_sat_q;

	// combinational datapath
	logic                          accept;
	logic                          f2_go;
	logic signed [DW-1:0]          mul_a;
	logic signed [BW-1:0]          mul_b;
	logic signed [DW-1:0]          drive2;
	logic signed [PW-1:0]          prod_d;
	logic signed [XW-1:0]          fb;
	logic signed [XW-1:0]          v_r;
	logic signed [STATE_WIDTH-1:0] store_sel;
	logic signed [STATE_WIDTH-1:0] u_val;
	logic signed [STATE_WIDTH-1:0] v_val;
	logic signed [STATE_WIDTH-1:0] y_val;
	logic signed [STATE_WIDTH-1:0] n_val;
	logic signed [LEVEL_WIDTH-1:0] l_val;
	logic                          u_flag;
	logic                          v_flag;
	logic                          y_flag;
	logic                          n_flag;
	logic                          l_flag;
	logic signed [XW-1:0]          lv_in;

	assign cfg.ready          = 1'b1;
	assign audio.ready        = (state_q == ST_IDLE);
	assign accept             = audio.valid && audio.ready;
	assign f2_go              = !out_valid_q || filtered.ready;
	assign filtered.valid     = out_valid_q;
	assign filtered.level     = level_q;
	assign filtered.saturated = out_sat_q;

	// select multiplier operands for the current step
	always_comb begin
		drive2 = (mode_q == MODE_HIGHPASS) ? (DW'(x_q) - DW'(o1_q)) : DW'(o1_q);
		case (state_q)
			ST_FB: begin
				mul_a = DW'(o1_q) - DW'(o2_q);
				mul_b = {1'b0, gain_q};
			end
			ST_M1: begin
				// highpass drives the first stage with the raw sample
				mul_a = ((mode_q == MODE_HIGHPASS) ? DW'(x_q) : DW'(drive_q)) - DW'(s1_q);
				mul_b = {1'b0, coef_q};
			end
			ST_M2: begin
				mul_a = drive2 - DW'(s2_q);
				mul_b = {1'b0, coef_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_d = PW'(mul_a) * PW'(mul_b);
	end

	// round, sum and clamp the registered product
	always_comb begin
		fb              = rnd(prod_q, RES_FRAC_BITS);
		{u_flag, u_val} = sat_st(XW'(x_q) + fb);
		v_r             = rnd(prod_q, COEF_FRAC_BITS);
		{v_flag, v_val} = sat_st(v_r);
		store_sel       = (state_q == ST_F2) ? s2_q : s1_q;
		{y_flag, y_val} = sat_st(XW'(v_val) + XW'(store_sel));
		{n_flag, n_val} = sat_st(XW'(y_val) + XW'(v_val));
		if (mode_q == MODE_HIGHPASS)
			lv_in = XW'(x_q) - XW'(o1_q) - XW'(y_val);
		else
			lv_in = XW'(y_val);
		{l_flag, l_val} = sat_lv(lv_in);
	end

	// sequencer, configuration and integrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_LOWPASS;
			coef_q      <= '0;
			gain_q      <= '0;
			s1_q        <= '0;
			s2_q        <= '0;
			o1_q        <= '0;
			o2_q        <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_MODE:      mode_q <= cfg.data[0];
					REG_CUTOFF:    coef_q <= cfg.data;
					REG_RESONANCE: gain_q <= cfg.data;
					default:       ;
				endcase
			end
			// drop the result once taken, unless a new one replaces it
			if (filtered.valid && filtered.ready && (state_q != ST_F2))
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (audio.clear_first) begin
							s1_q <= '0;
							s2_q <= '0;
							o1_q <= '0;
							o2_q <= '0;
						end
						state_q <= (mode_q == MODE_LOWPASS) ? ST_FB : ST_M1;
					end
				end
				ST_FB:   state_q <= ST_U;
				ST_U:    state_q <= ST_M1;
				ST_M1:   state_q <= ST_F1;
				ST_F1: begin
					o1_q    <= y_val;
					s1_q    <= n_val;
					state_q <= ST_M2;
				end
				ST_M2:   state_q <= ST_F2;
				ST_F2: begin
					// hold until the output register is free
					if (f2_go) begin
						o2_q        <= y_val;
						s2_q        <= n_val;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q   <= audio.sample;
					sat_q <= 1'b0;
				end
			end
			ST_FB, ST_M1, ST_M2: prod_q <= prod_d;
			ST_U: begin
				drive_q <= u_val;
				sat_q   <= sat_q | u_flag;
			end
			ST_F1:   sat_q <= sat_q | v_flag | y_flag | n_flag;
			ST_F2: begin
				if (f2_go) begin
					level_q   <= l_val;
					out_sat_q <= sat_q | v_flag | y_flag | n_flag | l_flag;
				end
			end
			default: ;
		endcase
	end

	// a taken sample always starts the sequencer
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("sequencer did not start after a sample request");

	// clearing zeroes every integrator value before it is used
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && audio.clear_first |=> s1_q == '0 && s2_q == '0 && o1_q == '0 && o2_q == '0)
		else $error("integrator state not cleared");

	// a new result comes only from the last update step
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_F2)
		else $error("result raised outside the final step");

	// state holds while no sample is in flight
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && !accept |=> $stable(s1_q) && $stable(s2_q) && $stable(o2_q))
		else $error("integrator state changed while idle");

	// the final step never overwrites a waiting result
	a_noloss: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_F2 && out_valid_q && !filtered.ready |=> state_q == ST_F2)
		else $error("result overwritten while stalled");

endmodule
